// ===== design/greedy_nearest_point_matcher_assert.svh =====
// assertion macros for the nearest point matcher
`ifndef GREEDY_NEAREST_POINT_MATCHER_ASSERT_SVH
`define GREEDY_NEAREST_POINT_MATCHER_ASSERT_SVH

// checked only out of reset
`define GNPM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("gnpm assertion failed");

// checked on every edge, reset included
`define GNPM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("gnpm assertion failed");

`endif

// ===== design/gnpm_pkg.sv =====
// shared constants and types of the nearest point matcher
package gnpm_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 31;
    localparam int COORD_W     = 24;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int DIST_W      = SQ_W + 1;
    localparam int LIMIT_W     = 50;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic                      claimed;
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              busy;
        logic              valid;
        logic              ok;
        logic [ADDR_W-1:0] idx;
        logic [DIST_W-1:0] sq_dist;
    } t_dist_res;

endpackage

// ===== design/gnpm_ram.sv =====
// simple dual port ram with registered read
module gnpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/gnpm_dist.sv =====
// squared distance pipeline with limit check
module gnpm_dist (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_claimed,
    input  logic [gnpm_pkg::ADDR_W-1:0]         i_idx,
    input  logic signed [gnpm_pkg::COORD_W-1:0] i_ref_x,
    input  logic signed [gnpm_pkg::COORD_W-1:0] i_ref_y,
    input  logic signed [gnpm_pkg::COORD_W-1:0] i_adj_x,
    input  logic signed [gnpm_pkg::COORD_W-1:0] i_adj_y,
    input  logic [gnpm_pkg::LIMIT_W-1:0]        i_limit_sq,
    output gnpm_pkg::t_dist_res                 o_res
);

    logic                               r_v1, r_v2, r_v3;
    logic [gnpm_pkg::ADDR_W-1:0]        r_idx1, r_idx2, r_idx3;
    logic signed [gnpm_pkg::DIFF_W-1:0] r_dx, r_dy;
    logic [gnpm_pkg::SQ_W-1:0]          r_sqx, r_sqy;
    logic [gnpm_pkg::DIST_W-1:0]        r_sum;
    logic signed [2*gnpm_pkg::DIFF_W-1:0] w_px, w_py;

    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid && !i_claimed;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_idx1 <= i_idx;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_dx   <= {i_ref_x[gnpm_pkg::COORD_W-1], i_ref_x}
                - {i_adj_x[gnpm_pkg::COORD_W-1], i_adj_x};
        r_dy   <= {i_ref_y[gnpm_pkg::COORD_W-1], i_ref_y}
                - {i_adj_y[gnpm_pkg::COORD_W-1], i_adj_y};
        r_sqx  <= w_px[gnpm_pkg::SQ_W-1:0];
        r_sqy  <= w_py[gnpm_pkg::SQ_W-1:0];
        r_sum  <= {1'b0, r_sqx} + {1'b0, r_sqy};
    end

    assign o_res.busy    = r_v1 | r_v2 | r_v3;
    assign o_res.valid   = r_v3;
    assign o_res.ok      = {{(gnpm_pkg::LIMIT_W-gnpm_pkg::DIST_W){1'b0}}, r_sum} < i_limit_sq;
    assign o_res.idx     = r_idx3;
    assign o_res.sq_dist = r_sum;

endmodule

// ===== design/greedy_nearest_point_matcher.sv =====
// Greedy nearest point matcher, top level.
// Reference points live in one table ram, one entry a word, read one entry per cycle.
// A load or clear word is done at acceptance. A query scans every stored entry once through
// the single ram read port, the three stage distance pipeline drains, then the best
// entry is read again and written back with its claimed mark set. The result shows
// in the output register when the output is free, and the next word is taken from that cycle.
// Only one word is in work at a time; a finished result waits in the output register
// while the next word is taken, and a second result still held back stalls the input.
// No clearing pass is needed after reset.
`include "greedy_nearest_point_matcher_assert.svh"

module greedy_nearest_point_matcher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_kind,
    input  logic [gnpm_pkg::ID_W-1:0]           i_node_id,
    input  logic signed [gnpm_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [gnpm_pkg::COORD_W-1:0] i_pos_y,
    input  logic signed [gnpm_pkg::COORD_W-1:0] i_adj_x,
    input  logic signed [gnpm_pkg::COORD_W-1:0] i_adj_y,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [gnpm_pkg::ID_W-1:0]           o_query_node,
    output logic                                o_found,
    output logic [gnpm_pkg::ID_W-1:0]           o_matched_id,
    output logic signed [gnpm_pkg::DIFF_W-1:0]  o_offset_x,
    output logic signed [gnpm_pkg::DIFF_W-1:0]  o_offset_y,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gnpm_pkg::LIMIT_W-1:0]        i_cfg_limit_sq
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WAIT,
        ST_RESULT
    } t_state;

    t_state r_state, n_state;

    logic [gnpm_pkg::LIMIT_W-1:0]        r_limit_sq;
    logic [gnpm_pkg::CNT_W-1:0]          r_count, n_count;
    logic [gnpm_pkg::CNT_W-1:0]          r_scan_idx, n_scan_idx;
    logic                                r_rd_vld;
    logic [gnpm_pkg::ADDR_W-1:0]         r_rd_idx;
    logic                                r_have, n_have;
    logic [gnpm_pkg::ADDR_W-1:0]         r_best_idx, n_best_idx;
    logic [gnpm_pkg::DIST_W-1:0]         r_best_dist, n_best_dist;
    logic [gnpm_pkg::ID_W-1:0]           r_q_node;
    logic signed [gnpm_pkg::COORD_W-1:0] r_q_px, r_q_py, r_q_ax, r_q_ay;
    logic                                r_res_found, n_res_found;
    logic [gnpm_pkg::ID_W-1:0]           r_res_id, n_res_id;
    logic signed [gnpm_pkg::DIFF_W-1:0]  r_res_ox, n_res_ox, r_res_oy, n_res_oy;
    logic                                r_out_valid, n_out_valid;
    logic [gnpm_pkg::ID_W-1:0]           r_out_node;
    logic                                r_out_found;
    logic [gnpm_pkg::ID_W-1:0]           r_out_id;
    logic signed [gnpm_pkg::DIFF_W-1:0]  r_out_ox, r_out_oy;

    logic                        w_in_acc;
    logic                        w_out_load;
    logic                        w_we, w_re, w_scan_rd;
    logic [gnpm_pkg::ADDR_W-1:0] w_waddr, w_raddr;
    gnpm_pkg::t_entry            w_wdata, w_rdata;
    gnpm_pkg::t_dist_res         w_dist;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == ST_RESULT) && (!r_out_valid || i_out_ready);
    assign w_scan_rd   = (r_state == ST_SCAN) && (r_scan_idx < r_count);

    gnpm_ram #(
        .WIDTH (gnpm_pkg::ENTRY_W),
        .DEPTH (gnpm_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    gnpm_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_rd_vld),
        .i_claimed  (w_rdata.claimed),
        .i_idx      (r_rd_idx),
        .i_ref_x    (w_rdata.x),
        .i_ref_y    (w_rdata.y),
        .i_adj_x    (r_q_ax),
        .i_adj_y    (r_q_ay),
        .i_limit_sq (r_limit_sq),
        .o_res      (w_dist)
    );

    // ram access
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[gnpm_pkg::ADDR_W-1:0];
        w_wdata = '{claimed: 1'b0, id: i_node_id, x: i_pos_x, y: i_pos_y};
        w_re    = 1'b0;
        w_raddr = r_scan_idx[gnpm_pkg::ADDR_W-1:0];
        if (r_state == ST_IDLE) begin
            w_we = w_in_acc && (i_kind == gnpm_pkg::KIND_LOAD)
                && (r_count < gnpm_pkg::CNT_W'(gnpm_pkg::TABLE_DEPTH));
        end
        if (r_state == ST_WAIT) begin
            w_we    = 1'b1;
            w_waddr = r_best_idx;
            w_wdata = '{claimed: 1'b1, id: w_rdata.id, x: w_rdata.x, y: w_rdata.y};
        end
        if (w_scan_rd) begin
            w_re = 1'b1;
        end
        if ((r_state == ST_DRAIN) && !w_dist.busy && r_have) begin
            w_re    = 1'b1;
            w_raddr = r_best_idx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan_idx  = r_scan_idx;
        n_have      = r_have;
        n_best_idx  = r_best_idx;
        n_best_dist = r_best_dist;
        n_res_found = r_res_found;
        n_res_id    = r_res_id;
        n_res_ox    = r_res_ox;
        n_res_oy    = r_res_oy;
        n_out_valid = r_out_valid && !i_out_ready;
        // best candidate update, earliest wins on ties
        if (w_dist.valid && w_dist.ok && (!r_have || (w_dist.sq_dist < r_best_dist))) begin
            n_have      = 1'b1;
            n_best_idx  = w_dist.idx;
            n_best_dist = w_dist.sq_dist;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_kind)
                        gnpm_pkg::KIND_LOAD: begin
                            if (w_we) begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        gnpm_pkg::KIND_CLEAR: begin
                            n_count = '0;
                        end
                        gnpm_pkg::KIND_QUERY: begin
                            n_scan_idx = '0;
                            n_have     = 1'b0;
                            n_state    = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_scan_rd) begin
                    n_scan_idx = r_scan_idx + 1'b1;
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_dist.busy) begin
                    if (r_have) begin
                        n_state = ST_WAIT;
                    end else begin
                        n_res_found = 1'b0;
                        n_res_id    = '0;
                        n_res_ox    = '0;
                        n_res_oy    = '0;
                        n_state     = ST_RESULT;
                    end
                end
            end
            ST_WAIT: begin
                n_res_found = 1'b1;
                n_res_id    = w_rdata.id;
                n_res_ox    = {w_rdata.x[gnpm_pkg::COORD_W-1], w_rdata.x}
                            - {r_q_px[gnpm_pkg::COORD_W-1], r_q_px};
                n_res_oy    = {w_rdata.y[gnpm_pkg::COORD_W-1], w_rdata.y}
                            - {r_q_py[gnpm_pkg::COORD_W-1], r_q_py};
                n_state     = ST_RESULT;
            end
            ST_RESULT: begin
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_scan_idx  <= '0;
            r_rd_vld    <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
            r_limit_sq  <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan_idx  <= n_scan_idx;
            r_rd_vld    <= w_scan_rd;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_limit_sq <= i_cfg_limit_sq;
            end
        end
        r_rd_idx    <= r_scan_idx[gnpm_pkg::ADDR_W-1:0];
        r_best_idx  <= n_best_idx;
        r_best_dist <= n_best_dist;
        r_res_found <= n_res_found;
        r_res_id    <= n_res_id;
        r_res_ox    <= n_res_ox;
        r_res_oy    <= n_res_oy;
        if (w_in_acc) begin
            r_q_node <= i_node_id;
            r_q_px   <= i_pos_x;
            r_q_py   <= i_pos_y;
            r_q_ax   <= i_adj_x;
            r_q_ay   <= i_adj_y;
        end
        if (w_out_load) begin
            r_out_node  <= r_q_node;
            r_out_found <= r_res_found;
            r_out_id    <= r_res_id;
            r_out_ox    <= r_res_ox;
            r_out_oy    <= r_res_oy;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_query_node = r_out_node;
    assign o_found      = r_out_found;
    assign o_matched_id = r_out_id;
    assign o_offset_x   = r_out_ox;
    assign o_offset_y   = r_out_oy;

    `GNPM_ASSERT(a_count_bound, r_count <= gnpm_pkg::CNT_W'(gnpm_pkg::TABLE_DEPTH))
    `GNPM_ASSERT(a_idle_empty, o_in_ready |-> (!w_dist.busy && !r_rd_vld))
    `GNPM_ASSERT(a_writeback_has_best, (r_state == ST_WAIT) |-> r_have)
    `GNPM_ASSERT(a_scan_bound, (r_state == ST_SCAN) |-> (r_scan_idx <= r_count))

endmodule
